FILE: sv/fba_pkg.sv
`default_nettype none

package fba_pkg;

	localparam int CMD_W      = 1;
	localparam int IDX_IN_W   = 4;
	localparam int AMOUNT_W   = 16;
	localparam int BLKNUM_W   = 5;
	localparam int SPACE_W    = 16;
	localparam int MODE_W     = 2;
	localparam int INUSE_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CMD_W-1:0] CMD_LOAD    = 1'b0;
	localparam logic [CMD_W-1:0] CMD_REQUEST = 1'b1;

	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

	localparam logic [MODE_W-1:0]  RESET_FIT_MODE      = MODE_FIRST;
	localparam logic [INUSE_W-1:0] RESET_BLOCKS_IN_USE = 5'd16;

	typedef struct packed {
		logic                granted;
		logic [BLKNUM_W-1:0] block_number;
		logic [SPACE_W-1:0]  space_left;
	} res_t;

endpackage

`default_nettype wire

FILE: sv/fba_mem.sv
`default_nettype none

module fba_mem #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output      logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/fba_scan.sv
`default_nettype none

module fba_scan #(
	parameter int MAX_BLOCKS = 16,
	parameter int SIZE_BITS  = 16,
	parameter int IDX_W      = 4,
	parameter int CNT_W      = 5
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output      logic                          busy,
	input  wire logic [fba_pkg::CMD_W-1:0]     cmd,
	input  wire logic [fba_pkg::IDX_IN_W-1:0]  block_index,
	input  wire logic [fba_pkg::AMOUNT_W-1:0]  amount,
	input  wire logic [fba_pkg::MODE_W-1:0]    fit_mode,
	input  wire logic [CNT_W-1:0]              scan_limit,
	output      logic                          mem_we,
	output      logic [IDX_W-1:0]              mem_waddr,
	output      logic [SIZE_BITS-1:0]          mem_wdata,
	output      logic                          mem_re,
	output      logic [IDX_W-1:0]              mem_raddr,
	input  wire logic [SIZE_BITS-1:0]          mem_rdata,
	output      logic                          res_valid,
	output      fba_pkg::res_t                 res
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              rd_ptr_q;
	logic [CNT_W-1:0]              limit_q;
	logic [fba_pkg::AMOUNT_W-1:0]  amount_q;
	logic [fba_pkg::MODE_W-1:0]    mode_q;
	logic                          rd_vld_s1;
	logic [IDX_W-1:0]              rd_idx_s1;
	logic                          found_q;
	logic [IDX_W-1:0]              pick_q;
	logic [SIZE_BITS-1:0]          held_q;
	logic                          res_valid_q;
	fba_pkg::res_t                 res_q;

	logic                          accept;
	logic                          load_wr;
	logic                          issue;
	logic                          fits;
	logic                          better;
	logic                          take;
	logic [31:0]                   idx_ext;
	logic [31:0]                   amt_ext;
	logic [31:0]                   diff;
	logic [SIZE_BITS-1:0]          new_size;
	logic [31:0]                   new_ext;
	logic [31:0]                   num_ext;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign idx_ext = 32'(block_index);
	assign amt_ext = 32'(amount);
	assign load_wr = accept && (cmd == fba_pkg::CMD_LOAD) && (idx_ext < 32'(MAX_BLOCKS));

	assign issue     = (state_q == ST_SCAN) && (rd_ptr_q < limit_q);
	assign mem_re    = issue;
	assign mem_raddr = rd_ptr_q[IDX_W-1:0];

	// candidate compare on the entry read last cycle
	always_comb begin
		fits = 32'(mem_rdata) >= 32'(amount_q);
		case (mode_q)
			fba_pkg::MODE_BEST:  better = mem_rdata < held_q;
			fba_pkg::MODE_WORST: better = mem_rdata > held_q;
			default:             better = 1'b0;
		endcase
		take = rd_vld_s1 && fits && (!found_q || better);
	end

	assign diff     = 32'(held_q) - 32'(amount_q);
	assign new_size = diff[SIZE_BITS-1:0];
	assign new_ext  = 32'(new_size);
	assign num_ext  = 32'(pick_q) + 32'd1;

	always_comb begin
		if (state_q == ST_DONE) begin
			mem_we    = found_q;
			mem_waddr = pick_q;
			mem_wdata = new_size;
		end else begin
			mem_we    = load_wr;
			mem_waddr = idx_ext[IDX_W-1:0];
			mem_wdata = amt_ext[SIZE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_vld_s1   <= issue;
			res_valid_q <= (state_q == ST_DONE);
			case (state_q)
				ST_IDLE: begin
					if (accept && (cmd == fba_pkg::CMD_REQUEST)) begin
						state_q <= ST_SCAN;
						found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (take) begin
						found_q <= 1'b1;
					end
					if (!issue) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ptr_q <= '0;
			limit_q  <= scan_limit;
			amount_q <= amount;
			mode_q   <= fit_mode;
		end else if (issue) begin
			rd_ptr_q <= rd_ptr_q + CNT_W'(1);
		end
		if (issue) begin
			rd_idx_s1 <= rd_ptr_q[IDX_W-1:0];
		end
		if (take) begin
			pick_q <= rd_idx_s1;
			held_q <= mem_rdata;
		end
		if (state_q == ST_DONE) begin
			res_q.granted      <= found_q;
			res_q.block_number <= found_q ? num_ext[fba_pkg::BLKNUM_W-1:0] : '0;
			res_q.space_left   <= found_q ? new_ext[fba_pkg::SPACE_W-1:0] : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

FILE: sv/fit_block_allocator.sv
`default_nettype none

// Free-size table for up to MAX_BLOCKS memory blocks with first, best or worst
// fit placement. A load (cmd 0) is taken while idle, writes the block's free
// size and raises no done; busy stays low. A request (cmd 1) keeps busy high
// through a scan of N = min(blocks_in_use, MAX_BLOCKS) entries, which reads one
// table entry per cycle through the single read port of the free-size memory,
// then through the last compare and the write-back of the chosen block. done
// pulses for one cycle right after, with granted, block_number and space_left
// valid in that cycle only; the receiver cannot stall it, so it must capture
// the transfer then. A new start may be given in that same cycle. Blocks
// scanned by a request must have been loaded since reset.
module fit_block_allocator #(
	parameter int MAX_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output      logic                            busy,
	input  wire logic [fba_pkg::CMD_W-1:0]       cmd,
	input  wire logic [fba_pkg::IDX_IN_W-1:0]    block_index,
	input  wire logic [fba_pkg::AMOUNT_W-1:0]    amount,
	output      logic                            done,
	output      logic                            granted,
	output      logic [fba_pkg::BLKNUM_W-1:0]    block_number,
	output      logic [fba_pkg::SPACE_W-1:0]     space_left,
	input  wire logic                            cfg_we,
	input  wire logic [fba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fba_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	logic [fba_pkg::MODE_W-1:0]  fit_mode_q;
	logic [fba_pkg::INUSE_W-1:0] blocks_in_use_q;
	logic [CNT_W-1:0]            scan_limit;

	logic                        mem_we;
	logic [IDX_W-1:0]            mem_waddr;
	logic [SIZE_BITS-1:0]        mem_wdata;
	logic                        mem_re;
	logic [IDX_W-1:0]            mem_raddr;
	logic [SIZE_BITS-1:0]        mem_rdata;
	fba_pkg::res_t               res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q      <= fba_pkg::RESET_FIT_MODE;
			blocks_in_use_q <= fba_pkg::RESET_BLOCKS_IN_USE;
		end else if (cfg_we) begin
			case (cfg_index)
				fba_pkg::CFG_FIT_MODE:      fit_mode_q      <= cfg_wdata[fba_pkg::MODE_W-1:0];
				fba_pkg::CFG_BLOCKS_IN_USE: blocks_in_use_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// saturate to the table depth
	assign scan_limit = (32'(blocks_in_use_q) > 32'(MAX_BLOCKS)) ?
		CNT_W'(MAX_BLOCKS) : CNT_W'(blocks_in_use_q);

	fba_mem #(
		.DEPTH  (MAX_BLOCKS),
		.WIDTH  (SIZE_BITS),
		.ADDR_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fba_scan #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_BITS  (SIZE_BITS),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.block_index (block_index),
		.amount      (amount),
		.fit_mode    (fit_mode_q),
		.scan_limit  (scan_limit),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.res_valid   (done),
		.res         (res)
	);

	assign granted      = res.granted;
	assign block_number = res.block_number;
	assign space_left   = res.space_left;

endmodule

`default_nettype wire

FILE: tb/sv/fit_block_allocator_test.sv
`timescale 1ns / 100ps

module fit_block_allocator_test;

	localparam int MAX_BLK = 16;
	localparam int SETTLE = 24;
	localparam int IDLE_LIMIT = 3000;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_JOBS = 48;
	localparam logic [fba_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic [fba_pkg::CMD_W-1:0]    cmd;
		logic [fba_pkg::IDX_IN_W-1:0] idx;
		logic [fba_pkg::AMOUNT_W-1:0] amount;
	} job_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [fba_pkg::CMD_W-1:0] cmd = fba_pkg::CMD_LOAD;
	logic [fba_pkg::IDX_IN_W-1:0] block_index = '0;
	logic [fba_pkg::AMOUNT_W-1:0] amount = '0;
	logic cfg_we = 1'b0;
	logic [fba_pkg::CFG_IDX_W-1:0] cfg_index = fba_pkg::CFG_FIT_MODE;
	logic [fba_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic busy;
	logic done;
	logic granted;
	logic [fba_pkg::BLKNUM_W-1:0] block_number;
	logic [fba_pkg::SPACE_W-1:0] space_left;

	// shadow of the block's state and registers
	logic [fba_pkg::AMOUNT_W-1:0] shadow_free [MAX_BLK];
	logic [fba_pkg::MODE_W-1:0] fit_mode = fba_pkg::RESET_FIT_MODE;
	logic [fba_pkg::INUSE_W-1:0] in_use = fba_pkg::RESET_BLOCKS_IN_USE;

	job_t pending_jobs [$];
	fba_pkg::res_t due_grants [$];
	job_t cur;
	int burst_left = 0;
	int gap_left = 0;
	logic drain_hold = 1'b0;
	int jobs_taken = 0;
	int grants_seen = 0;
	int settings = 1;
	int errors = 0;
	int idle_cycles = 0;

	fit_block_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.block_index  (block_index),
		.amount       (amount),
		.done         (done),
		.granted      (granted),
		.block_number (block_number),
		.space_left   (space_left),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic fba_pkg::res_t allocate(input logic [fba_pkg::AMOUNT_W-1:0] want);
		fba_pkg::res_t r;
		int scan;
		int pick;
		logic hit;
		r = '0;
		pick = 0;
		hit = 1'b0;
		scan = (in_use > MAX_BLK) ? MAX_BLK : in_use;
		for (int j = 0; j < scan; j++) begin
			if (shadow_free[j] >= want) begin
				if (!hit) begin
					hit = 1'b1;
					pick = j;
					if (fit_mode != fba_pkg::MODE_BEST && fit_mode != fba_pkg::MODE_WORST)
						break;
				end else if ((fit_mode == fba_pkg::MODE_BEST &&
						shadow_free[j] < shadow_free[pick]) ||
						(fit_mode == fba_pkg::MODE_WORST &&
						shadow_free[j] > shadow_free[pick])) begin
					pick = j;
				end
			end
		end
		if (hit) begin
			shadow_free[pick] = shadow_free[pick] - want;
			r.granted = 1'b1;
			r.block_number = fba_pkg::BLKNUM_W'(pick + 1);
			r.space_left = shadow_free[pick];
		end
		return r;
	endfunction

	function automatic logic [fba_pkg::AMOUNT_W-1:0] pick_size();
		case ($urandom % 8)
			0: return '0;
			1: return '1;
			2, 3: return fba_pkg::AMOUNT_W'($urandom_range(0, 255));
			4, 5: return fba_pkg::AMOUNT_W'(100 * $urandom_range(1, 8));
			default: return fba_pkg::AMOUNT_W'($urandom);
		endcase
	endfunction

	task automatic add_job(input logic [fba_pkg::CMD_W-1:0] c, input int i,
			input logic [fba_pkg::AMOUNT_W-1:0] a);
		job_t j;
		j.cmd = c;
		j.idx = fba_pkg::IDX_IN_W'(i);
		j.amount = a;
		pending_jobs.push_back(j);
	endtask

	task automatic set_reg(input logic [fba_pkg::CFG_IDX_W-1:0] idx,
			input logic [fba_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		if (idx == fba_pkg::CFG_FIT_MODE)
			fit_mode = data[fba_pkg::MODE_W-1:0];
		else
			in_use = data[fba_pkg::INUSE_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_mode(input logic [fba_pkg::MODE_W-1:0] m);
		logic [fba_pkg::CFG_DATA_W-1:0] d;
		d = fba_pkg::CFG_DATA_W'($urandom);
		d[fba_pkg::MODE_W-1:0] = m;
		set_reg(fba_pkg::CFG_FIT_MODE, d);
	endtask

	task automatic drain();
		while (pending_jobs.size() != 0 || start || busy || due_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// driver: bursts of transfers with random gaps, now and then waiting for all grants
	always @(posedge clk or negedge arst_n) begin : drive_jobs
		logic took;
		logic go;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			took = start && !busy;
			go = 1'b0;
			if (took) begin
				jobs_taken++;
				if (cur.cmd == fba_pkg::CMD_LOAD)
					shadow_free[cur.idx] = cur.amount;
				else
					due_grants.push_back(allocate(cur.amount));
			end
			if (!start || took) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (drain_hold) begin
					if (due_grants.size() == 0 && !busy)
						drain_hold = 1'b0;
				end else if (pending_jobs.size() != 0) begin
					cur = pending_jobs.pop_front();
					cmd <= cur.cmd;
					block_index <= cur.idx;
					amount <= cur.amount;
					go = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 20);
						case ($urandom % 10)
							0, 1, 2, 3: gap_left = 0;
							4, 5, 6, 7: gap_left = $urandom_range(1, 4);
							8: gap_left = $urandom_range(5, 30);
							default: drain_hold = 1'b1;
						endcase
					end
				end
				start <= go;
			end
		end
	end

	// monitor: done cannot be held off, every pulse is a transfer
	always @(posedge clk) begin : check_results
		fba_pkg::res_t want;
		if (arst_n && done) begin
			grants_seen++;
			if (due_grants.size() == 0) begin
				$error("result with nothing expected: granted %0b block_number %0d space_left %0d",
					granted, block_number, space_left);
				errors++;
			end else begin
				want = due_grants.pop_front();
				if (granted !== want.granted) begin
					$error("granted: expected %0b, got %0b", want.granted, granted);
					errors++;
				end
				if (block_number !== want.block_number) begin
					$error("block_number: expected %0d, got %0d", want.block_number, block_number);
					errors++;
				end
				if (space_left !== want.space_left) begin
					$error("space_left: expected %0d, got %0d", want.space_left, space_left);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("fit_block_allocator_test: errors");
			$finish;
		end
	end

	initial begin : run
		logic [fba_pkg::AMOUNT_W-1:0] sizes [MAX_BLK];
		logic [fba_pkg::MODE_W-1:0] m;
		logic [fba_pkg::INUSE_W-1:0] n;
		sizes = '{16'd0, 16'd65535, 16'd100, 16'd500, 16'd100, 16'd500, 16'd1, 16'd2,
			16'd3, 16'd4, 16'd300, 16'd300, 16'd700, 16'd700, 16'd50, 16'd65534};
		for (int i = 0; i < MAX_BLK; i++)
			shadow_free[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// every block loaded before any request scans it
		for (int i = 0; i < MAX_BLK; i++)
			add_job(fba_pkg::CMD_LOAD, i, sizes[i]);
		add_job(fba_pkg::CMD_REQUEST, 0, '0);
		add_job(fba_pkg::CMD_REQUEST, 0, '1);
		add_job(fba_pkg::CMD_REQUEST, 0, '1);
		drain();
		set_mode(fba_pkg::MODE_BEST);
		add_job(fba_pkg::CMD_REQUEST, 5, 16'd100);
		add_job(fba_pkg::CMD_REQUEST, 9, 16'd100);
		drain();
		set_mode(fba_pkg::MODE_WORST);
		add_job(fba_pkg::CMD_REQUEST, 15, 16'd300);
		add_job(fba_pkg::CMD_REQUEST, 0, 16'd65000);
		drain();
		set_reg(fba_pkg::CFG_BLOCKS_IN_USE, 5'd0);
		add_job(fba_pkg::CMD_REQUEST, 0, '0);
		drain();
		set_mode(MODE_SPARE);
		set_reg(fba_pkg::CFG_BLOCKS_IN_USE, 5'd31);
		add_job(fba_pkg::CMD_REQUEST, 0, 16'd200);
		drain();
		settings += 4;

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin m = fba_pkg::MODE_FIRST; n = 5'd1; end
				1: begin m = fba_pkg::MODE_BEST; n = 5'd16; end
				2: begin m = fba_pkg::MODE_WORST; n = 5'd31; end
				3: begin m = MODE_SPARE; n = 5'd0; end
				default: begin
					m = fba_pkg::MODE_W'($urandom_range(0, 3));
					case ($urandom % 20)
						0, 1, 2: n = fba_pkg::INUSE_W'($urandom_range(0, 1));
						3, 4, 5: n = fba_pkg::INUSE_W'($urandom_range(17, 31));
						6, 7, 8, 9: n = 5'd16;
						default: n = fba_pkg::INUSE_W'($urandom_range(1, 16));
					endcase
				end
			endcase
			set_mode(m);
			set_reg(fba_pkg::CFG_BLOCKS_IN_USE, n);
			settings++;
			for (int k = 0; k < PHASE_JOBS; k++) begin
				if ($urandom % 100 < 45)
					add_job(fba_pkg::CMD_LOAD, $urandom_range(0, MAX_BLK - 1), pick_size());
				else
					add_job(fba_pkg::CMD_REQUEST, $urandom_range(0, MAX_BLK - 1), pick_size());
			end
			drain();
		end

		$display("%0d transfers taken, %0d allocation results checked", jobs_taken, grants_seen);
		$display("%0d register settings across first, best, worst and spare fit modes", settings);
		if (errors == 0)
			$display("fit_block_allocator_test: clean");
		else
			$display("fit_block_allocator_test: errors");
		$finish;
	end

endmodule
